@@ sv/dlts_pkg.sv @@
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and constants for the draft length test-and-hold selector.
// ----------------------------------------------------------------------------
package dlts_pkg;

    localparam int MAX_CANDIDATES = 4;
    localparam int CAND_IDX_W     = 2;
    localparam int CAND_CNT_W     = 3;

    localparam int LEN_W    = 8;
    localparam int FUNC_W   = 2;
    localparam int VUS_W    = 32;
    localparam int TOK_W    = 20;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int SUM_W    = 48;
    localparam int ROUND_W  = 8;
    localparam int HOLD_W   = 20;
    localparam int MULT_W   = 4;
    localparam int BASE_W   = 16;

    // Serial divider geometry.
    localparam int DIV_W      = 48;
    localparam int DVS_W      = 32;
    localparam int DIV_CNT_W  = 6;
    localparam int UTIL_FRAC  = 16;
    localparam logic [DIV_CNT_W-1:0] UTIL_STEPS = 6'd36;
    localparam logic [DIV_CNT_W-1:0] AVG_STEPS  = 6'd48;

    localparam logic [MULT_W-1:0] HOLD_MULT_MAX = 4'd8;

    // Input item function codes.
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_VERIFY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ROUND   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAFT_CAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_ROUNDS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_BASE   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic restart;
        logic verify;
        logic mark;
        logic hold_step;
        logic start_udiv;
        logic acc;
        logic start_adiv;
        logic decide;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              enable;
        logic              time_pending;
        logic              testing;
        logic              rounds_full;
        logic              div_done;
        logic              out_free;
    } status_t;

endpackage

@@ sv/dlts_div.sv @@
// ----------------------------------------------------------------------------
// dlts_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlts_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [dlts_pkg::DIV_CNT_W-1:0]  steps,
    input  logic [dlts_pkg::DIV_W-1:0]      dividend,
    input  logic [dlts_pkg::DVS_W-1:0]      divisor,
    output logic                            done,
    output logic [dlts_pkg::DIV_W-1:0]      quotient
);
    import dlts_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       rem_sh;
    logic [DVS_W:0]       diff;

    // The dividend is left aligned so that only the useful bits are walked.
    assign rem_sh = {rem_reg, q_reg[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign done   = busy_reg && (cnt_reg == '0);
    assign quotient = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (!diff[DVS_W])
                begin
                    rem_next = diff[DVS_W-1:0];
                    q_next   = {q_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DVS_W-1:0];
                    q_next   = {q_reg[DIV_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

@@ sv/dlts_dp.sv @@
// ----------------------------------------------------------------------------
// dlts_dp
// Datapath: configuration, selector state, divider and output register.
// ----------------------------------------------------------------------------
module dlts_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dlts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dlts_pkg::CFG_W-1:0]        cfg_data,
    input  logic [dlts_pkg::FUNC_W-1:0]       func,
    input  logic [dlts_pkg::VUS_W-1:0]        verify_us,
    input  logic [dlts_pkg::TOK_W-1:0]        tokens_total,
    input  dlts_pkg::cmd_t                    cmd,
    output dlts_pkg::status_t                 status,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [dlts_pkg::LEN_W-1:0]        draft_len,
    output logic                              in_test
);
    import dlts_pkg::*;

    // Configuration registers.
    logic               enable_reg;
    logic [LEN_W-1:0]   cap_reg;
    logic [ROUND_W-1:0] rounds_cfg_reg;
    logic [BASE_W-1:0]  base_reg;

    // Latched input transaction.
    logic [FUNC_W-1:0]  func_reg;
    logic [VUS_W-1:0]   vus_reg;
    logic [TOK_W-1:0]   tok_reg;

    // Selector state.
    logic [LEN_W-1:0]      cand_reg [MAX_CANDIDATES];
    logic [LEN_W-1:0]      cand_next [MAX_CANDIDATES];
    logic [CAND_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  testing_reg, testing_next;
    logic [CAND_IDX_W-1:0] tidx_reg, tidx_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [ROUND_W-1:0]    seen_reg, seen_next;
    logic [HOLD_W-1:0]     hold_reg, hold_next;
    logic [MULT_W-1:0]     mult_reg, mult_next;
    logic [LEN_W-1:0]      best_len_reg, best_len_next;
    logic [SUM_W-1:0]      best_avg_reg, best_avg_next;
    logic                  best_valid_reg, best_valid_next;
    logic [VUS_W-1:0]      ptime_reg, ptime_next;
    logic                  tpend_reg, tpend_next;
    logic [TOK_W-1:0]      mark_reg, mark_next;

    logic                  out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]      out_len_reg;
    logic                  out_test_reg;

    // Divider hookup.
    logic                  div_start;
    logic [DIV_CNT_W-1:0]  div_steps;
    logic [DIV_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_q;

    logic [TOK_W-1:0]      dtok;
    logic [ROUND_W-1:0]    need;
    logic [LEN_W-1:0]      mid;
    logic [LEN_W-1:0]      cand_sel;
    logic                  better;
    logic [LEN_W-1:0]      win_len;
    logic                  last_cand;
    logic [MULT_W:0]       mult_dbl;
    logic [MULT_W-1:0]     mult_new;
    logic [BASE_W-1:0]     base_eff;
    logic [HOLD_W-1:0]     hold_prod;
    logic [CAND_CNT_W-1:0] cnt_clamp;
    logic [CAND_IDX_W-1:0] last_idx;
    logic [CAND_IDX_W-1:0] cur_idx;
    logic [LEN_W-1:0]      cur_len;

    assign dtok = tok_reg - mark_reg;
    assign need = (rounds_cfg_reg == '0) ? ROUND_W'(1) : rounds_cfg_reg;
    assign mid  = (cap_reg[LEN_W-1:1] < LEN_W'(2)) ? LEN_W'(2)
                                                    : {1'b0, cap_reg[LEN_W-1:1]};

    assign div_start    = cmd.start_udiv | cmd.start_adiv;
    assign div_steps    = cmd.start_udiv ? UTIL_STEPS : AVG_STEPS;
    assign div_dividend = cmd.start_udiv
                        ? {dtok, {(DIV_W-TOK_W){1'b0}}}
                        : sum_reg;
    assign div_divisor  = cmd.start_udiv ? ptime_reg : DVS_W'(seen_reg);

    dlts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // End-of-candidate decision terms.
    assign cand_sel  = cand_reg[tidx_reg];
    assign better    = !best_valid_reg || (div_q > best_avg_reg);
    assign win_len   = better ? cand_sel : best_len_reg;
    assign last_cand = (CAND_CNT_W'(tidx_reg) + CAND_CNT_W'(1)) >= cnt_reg;
    assign mult_dbl  = {mult_reg, 1'b0};
    assign mult_new  = (win_len != '0)
                     ? MULT_W'(1)
                     : ((mult_dbl > (MULT_W+1)'(HOLD_MULT_MAX))
                        ? HOLD_MULT_MAX : mult_dbl[MULT_W-1:0]);
    assign base_eff  = (base_reg == '0) ? BASE_W'(1) : base_reg;
    assign hold_prod = HOLD_W'(base_eff) * HOLD_W'(mult_new);

    // Answer selection.
    assign cnt_clamp = (cnt_reg == '0) ? CAND_CNT_W'(1)
                     : ((cnt_reg > CAND_CNT_W'(MAX_CANDIDATES))
                        ? CAND_CNT_W'(MAX_CANDIDATES) : cnt_reg);
    assign last_idx  = CAND_IDX_W'(cnt_clamp - CAND_CNT_W'(1));
    assign cur_idx   = (tidx_reg > last_idx) ? last_idx : tidx_reg;
    assign cur_len   = !enable_reg ? cap_reg
                     : (!testing_reg ? best_len_reg : cand_reg[cur_idx]);

    always_comb
    begin
        for (int i = 0; i < MAX_CANDIDATES; i++)
        begin
            cand_next[i] = cand_reg[i];
        end
        cnt_next        = cnt_reg;
        testing_next    = testing_reg;
        tidx_next       = tidx_reg;
        sum_next        = sum_reg;
        seen_next       = seen_reg;
        hold_next       = hold_reg;
        mult_next       = mult_reg;
        best_len_next   = best_len_reg;
        best_avg_next   = best_avg_reg;
        best_valid_next = best_valid_reg;
        ptime_next      = ptime_reg;
        tpend_next      = tpend_reg;
        mark_next       = mark_reg;

        if (cmd.restart)
        begin
            for (int i = 0; i < MAX_CANDIDATES; i++)
            begin
                cand_next[i] = '0;
            end
            if (cap_reg == LEN_W'(0))
            begin
                cnt_next = CAND_CNT_W'(1);
            end
            else if (cap_reg == LEN_W'(1))
            begin
                cand_next[1] = LEN_W'(1);
                cnt_next     = CAND_CNT_W'(2);
            end
            else if (cap_reg == LEN_W'(2))
            begin
                cand_next[1] = LEN_W'(1);
                cand_next[2] = cap_reg;
                cnt_next     = CAND_CNT_W'(3);
            end
            else
            begin
                cand_next[1] = LEN_W'(1);
                cand_next[2] = mid;
                cand_next[3] = cap_reg;
                cnt_next     = CAND_CNT_W'(4);
            end
            testing_next    = 1'b1;
            tidx_next       = '0;
            sum_next        = '0;
            seen_next       = '0;
            best_avg_next   = '0;
            best_valid_next = 1'b0;
            best_len_next   = cap_reg;
            hold_next       = '0;
            mult_next       = MULT_W'(1);
            tpend_next      = 1'b0;
            ptime_next      = VUS_W'(1);
            mark_next       = '0;
        end

        if (cmd.verify)
        begin
            ptime_next = (vus_reg == '0) ? VUS_W'(1) : vus_reg;
            tpend_next = 1'b1;
        end

        if (cmd.mark)
        begin
            mark_next = tok_reg;
        end

        if (cmd.hold_step)
        begin
            tpend_next = 1'b0;
            mark_next  = tok_reg;
            if (hold_reg <= HOLD_W'(1))
            begin
                // Hold is over: a fresh test phase starts.
                hold_next       = '0;
                testing_next    = 1'b1;
                tidx_next       = '0;
                sum_next        = '0;
                seen_next       = '0;
                best_avg_next   = '0;
                best_valid_next = 1'b0;
                best_len_next   = cap_reg;
            end
            else
            begin
                hold_next = hold_reg - HOLD_W'(1);
            end
        end

        if (cmd.acc)
        begin
            sum_next   = sum_reg + div_q;
            seen_next  = seen_reg + ROUND_W'(1);
            tpend_next = 1'b0;
            mark_next  = tok_reg;
        end

        if (cmd.decide)
        begin
            if (better)
            begin
                best_avg_next   = div_q;
                best_valid_next = 1'b1;
                best_len_next   = cand_sel;
            end
            sum_next  = '0;
            seen_next = '0;
            if (last_cand)
            begin
                testing_next = 1'b0;
                mult_next    = mult_new;
                hold_next    = hold_prod;
                tidx_next    = '0;
            end
            else
            begin
                tidx_next = tidx_reg + CAND_IDX_W'(1);
            end
        end
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            cap_reg        <= LEN_W'(16);
            rounds_cfg_reg <= ROUND_W'(4);
            base_reg       <= BASE_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:      enable_reg     <= cfg_data[0];
                CFG_DRAFT_CAP:   cap_reg        <= cfg_data[LEN_W-1:0];
                CFG_TEST_ROUNDS: rounds_cfg_reg <= cfg_data[ROUND_W-1:0];
                CFG_HOLD_BASE:   base_reg       <= cfg_data[BASE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CANDIDATES; i++)
            begin
                cand_reg[i] <= '0;
            end
            cnt_reg        <= CAND_CNT_W'(1);
            testing_reg    <= 1'b1;
            tidx_reg       <= '0;
            sum_reg        <= '0;
            seen_reg       <= '0;
            hold_reg       <= '0;
            mult_reg       <= MULT_W'(1);
            best_len_reg   <= LEN_W'(16);
            best_avg_reg   <= '0;
            best_valid_reg <= 1'b0;
            ptime_reg      <= VUS_W'(1);
            tpend_reg      <= 1'b0;
            mark_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < MAX_CANDIDATES; i++)
            begin
                cand_reg[i] <= cand_next[i];
            end
            cnt_reg        <= cnt_next;
            testing_reg    <= testing_next;
            tidx_reg       <= tidx_next;
            sum_reg        <= sum_next;
            seen_reg       <= seen_next;
            hold_reg       <= hold_next;
            mult_reg       <= mult_next;
            best_len_reg   <= best_len_next;
            best_avg_reg   <= best_avg_next;
            best_valid_reg <= best_valid_next;
            ptime_reg      <= ptime_next;
            tpend_reg      <= tpend_next;
            mark_reg       <= mark_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            vus_reg  <= verify_us;
            tok_reg  <= tokens_total;
        end
        if (cmd.load_out)
        begin
            out_len_reg  <= cur_len;
            out_test_reg <= testing_reg;
        end
    end

    assign status.func         = func_reg;
    assign status.enable       = enable_reg;
    assign status.time_pending = tpend_reg;
    assign status.testing      = testing_reg;
    assign status.rounds_full  = seen_reg >= need;
    assign status.div_done     = div_done;
    assign status.out_free     = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign draft_len = out_len_reg;
    assign in_test   = out_test_reg;

endmodule

@@ sv/dlts_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlts_ctrl
// Controller: sequences one transaction through the datapath.
// ----------------------------------------------------------------------------
module dlts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  dlts_pkg::status_t status,
    output dlts_pkg::cmd_t    cmd
);
    import dlts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_UDIV   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_ADIV   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                case (status.func)
                    FUNC_RESTART: cmd.restart = 1'b1;
                    FUNC_VERIFY:  cmd.verify  = status.enable;
                    FUNC_ROUND:
                    begin
                        if (!status.enable || !status.time_pending)
                        begin
                            cmd.mark = 1'b1;
                        end
                        else if (status.testing)
                        begin
                            cmd.start_udiv = 1'b1;
                            state_next     = S_UDIV;
                        end
                        else
                        begin
                            cmd.hold_step = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_UDIV:
            begin
                if (status.div_done)
                begin
                    cmd.acc    = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.rounds_full)
                begin
                    cmd.start_adiv = 1'b1;
                    state_next     = S_ADIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_ADIV:
            begin
                if (status.div_done)
                begin
                    cmd.decide = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/draft_length_test_and_hold_selector_unit.sv @@
// ----------------------------------------------------------------------------
// draft_length_test_and_hold_selector_unit
// Chooses the speculative draft length by alternating test and hold phases.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one output transaction carrying the
// draft length for the next round and the test-phase flag. Transactions are
// handled one at a time: a restart, a verify-time report, a round that only
// moves the token mark, a hold round and an unknown code each pass from
// decode to the final state, which loads the output register and returns
// to idle, where the next transaction can be accepted. A measured test round
// runs the shared serial divider for the utility, 36 quotient bits at one bit
// per cycle, and then loads the output register; the round that closes a
// candidate first runs the divider a second time for the 48-bit mean. The
// output register must be free to be loaded; while a result is stalled the
// controller waits in its final state until the register empties.
// The output register lets the next transaction be accepted while the
// previous result is still stalled.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data, and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module draft_length_test_and_hold_selector_unit (
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [dlts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dlts_pkg::CFG_W-1:0]        cfg_data,

    // Input channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dlts_pkg::FUNC_W-1:0]       func,
    input  logic [dlts_pkg::VUS_W-1:0]        verify_us,
    input  logic [dlts_pkg::TOK_W-1:0]        tokens_total,

    // Output channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dlts_pkg::LEN_W-1:0]        draft_len,
    output logic                              in_test
);
    import dlts_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller walks each transaction through decode, the optional
    // utility and mean divisions, and the final load of the output register.
    dlts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the candidate list, the
    // measurement and hold state, the serial divider and the output register.
    dlts_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .verify_us    (verify_us),
        .tokens_total (tokens_total),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .draft_len    (draft_len),
        .in_test      (in_test)
    );

endmodule

@@ bench/tb_draft_length_test_and_hold_selector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_draft_length_test_and_hold_selector_unit
// Self-checking bench for the draft length test-and-hold selector.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a clocked driver. At every accepted input
// transaction a shadow copy of the selector (candidate list, test and hold
// bookkeeping, Q.16 utility math) works out the draft length and test flag
// that the block must answer. A clocked monitor pops those answers in order
// and compares them field by field. The run walks through several register
// settings, including the extremes, with different idle and stall mixes and
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_draft_length_test_and_hold_selector_unit;

    import dlts_pkg::*;

    // The package names only the three defined operations; the fourth code is
    // legal on the wire and must leave the state alone.
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 600;
    localparam int unsigned TAIL_CYCLES = 100;

    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [VUS_W-1:0]  vus;
        logic [TOK_W-1:0]  tok;
    } item_t;

    typedef struct {
        logic [LEN_W-1:0] len;
        logic             test;
    } length_answer_t;

    // Clock, reset and every block input start at known values.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func = FUNC_RESTART;
    logic [VUS_W-1:0]     verify_us = '0;
    logic [TOK_W-1:0]     tokens_total = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [LEN_W-1:0]     draft_len;
    logic                 in_test;

    item_t          pending_items[$];
    length_answer_t expected_answers[$];

    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          pressure_armed = 1'b0;
    logic        holding_off = 1'b0;
    logic [TOK_W-1:0] tok_cursor = '0;

    // Shadow copies of the configuration registers, at their reset values.
    logic              adapt_on = 1'b0;
    logic [LEN_W-1:0]  cap_reg = 8'd16;
    logic [7:0]        rounds_reg = 8'd4;
    logic [BASE_W-1:0] hold_base_reg = 16'd16;

    // Shadow selector state, at its reset values.
    logic [LEN_W-1:0]      cand [MAX_CANDIDATES] = '{default: '0};
    logic [CAND_CNT_W-1:0] cand_cnt = 3'd1;
    logic                  testing_q = 1'b1;
    logic [CAND_IDX_W-1:0] cand_pos = '0;
    logic [SUM_W-1:0]      util_acc = '0;
    logic [ROUND_W-1:0]    rounds_q = '0;
    logic [HOLD_W-1:0]     hold_left_q = '0;
    logic [MULT_W-1:0]     hold_mult_q = 4'd1;
    logic [LEN_W-1:0]      best_len_q = 8'd16;
    logic [SUM_W-1:0]      best_avg_q = '0;
    logic                  best_valid_q = 1'b0;
    logic [VUS_W-1:0]      pend_time = 32'd1;
    logic                  time_pend = 1'b0;
    logic [TOK_W-1:0]      tok_mark = '0;

    draft_length_test_and_hold_selector_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .verify_us    (verify_us),
        .tokens_total (tokens_total),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .draft_len    (draft_len),
        .in_test      (in_test)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A new test phase: every candidate is measured again from scratch and
    // the held length falls back to the live cap until a winner is found.
    task automatic reopen_test();
        testing_q    = 1'b1;
        cand_pos     = '0;
        util_acc     = '0;
        rounds_q     = '0;
        best_avg_q   = '0;
        best_valid_q = 1'b0;
        best_len_q   = cap_reg;
    endtask

    // Applies one accepted transaction to the shadow selector and queues the
    // answer the block owes for it.
    task automatic advance_selector(input item_t it);
        logic [TOK_W-1:0]      dtok;
        logic [VUS_W-1:0]      divisor;
        logic [35:0]           util;
        logic [SUM_W-1:0]      mean;
        logic [MULT_W:0]       mult_x2;
        logic [LEN_W-1:0]      mid;
        logic [CAND_CNT_W-1:0] n;
        logic [CAND_CNT_W-1:0] last;
        logic [CAND_IDX_W-1:0] idx;
        logic [7:0]            need;
        logic [BASE_W-1:0]     base;
        length_answer_t        ans;
        case (it.op)
            FUNC_RESTART:
            begin
                // The candidate list is rebuilt from the live cap even while
                // adaptation is off. Entries past the count read as zero.
                cand = '{default: '0};
                n = 3'd1;
                if (cap_reg >= 8'd1)
                begin
                    cand[n[1:0]] = 8'd1;
                    n = n + 3'd1;
                end
                if (cap_reg >= 8'd3)
                begin
                    mid = cap_reg >> 1;
                    if (mid < 8'd2)
                        mid = 8'd2;
                    cand[n[1:0]] = mid;
                    n = n + 3'd1;
                end
                if (cap_reg >= 8'd2)
                begin
                    cand[n[1:0]] = cap_reg;
                    n = n + 3'd1;
                end
                cand_cnt = n;
                reopen_test();
                hold_left_q = '0;
                hold_mult_q = 4'd1;
                time_pend   = 1'b0;
                pend_time   = 32'd1;
                tok_mark    = '0;
            end
            FUNC_VERIFY:
            begin
                if (adapt_on)
                begin
                    pend_time = (it.vus == '0) ? 32'd1 : it.vus;
                    time_pend = 1'b1;
                end
            end
            FUNC_ROUND:
            begin
                if (!adapt_on || !time_pend)
                    tok_mark = it.tok;
                else
                begin
                    dtok    = it.tok - tok_mark;
                    divisor = (pend_time == '0) ? 32'd1 : pend_time;
                    util    = {dtok, 16'h0000} / divisor;
                    time_pend = 1'b0;
                    if (testing_q)
                    begin
                        util_acc = util_acc + SUM_W'(util);
                        rounds_q = rounds_q + 8'd1;
                        need = (rounds_reg == '0) ? 8'd1 : rounds_reg;
                        if (rounds_q >= need)
                        begin
                            idx  = cand_pos;
                            mean = util_acc / SUM_W'(rounds_q);
                            if (!best_valid_q || mean > best_avg_q)
                            begin
                                best_avg_q   = mean;
                                best_valid_q = 1'b1;
                                best_len_q   = cand[idx];
                            end
                            util_acc = '0;
                            rounds_q = '0;
                            if ({1'b0, idx} + 3'd1 >= cand_cnt)
                            begin
                                // Last candidate done: hold the winner. A zero
                                // winner stretches the hold, up to eight times.
                                testing_q = 1'b0;
                                if (best_len_q == '0)
                                begin
                                    mult_x2 = {hold_mult_q, 1'b0};
                                    hold_mult_q = (mult_x2 > 5'd8) ? HOLD_MULT_MAX
                                                                   : mult_x2[MULT_W-1:0];
                                end
                                else
                                    hold_mult_q = 4'd1;
                                base = (hold_base_reg == '0) ? 16'd1 : hold_base_reg;
                                hold_left_q = HOLD_W'(32'(base) * 32'(hold_mult_q));
                                cand_pos = '0;
                            end
                            else
                                cand_pos = idx + 2'd1;
                        end
                    end
                    else
                    begin
                        if (hold_left_q <= 20'd1)
                        begin
                            hold_left_q = '0;
                            reopen_test();
                        end
                        else
                            hold_left_q = hold_left_q - 20'd1;
                    end
                    tok_mark = it.tok;
                end
            end
            default:
            begin
            end
        endcase

        if (!adapt_on)
            ans.len = cap_reg;
        else if (!testing_q)
            ans.len = best_len_q;
        else
        begin
            // Clamp the index into the live part of the list.
            last = cand_cnt;
            if (last < 3'd1)
                last = 3'd1;
            if (last > 3'd4)
                last = 3'd4;
            last = last - 3'd1;
            ans.len = ({1'b0, cand_pos} > last) ? cand[last[1:0]] : cand[cand_pos];
        end
        ans.test = testing_q;
        expected_answers.insert(expected_answers.size(), ans);
    endtask

    // Input driver. The payload only moves when the previous transaction was
    // taken or nothing was on offer, so a stalled item stays put.
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        item_t nxt;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            func         <= FUNC_RESTART;
            verify_us    <= '0;
            tokens_total <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                nxt.op  = func;
                nxt.vus = verify_us;
                nxt.tok = tokens_total;
                advance_selector(nxt);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    nxt = pending_items.pop_front();
                    in_valid     <= 1'b1;
                    func         <= nxt.op;
                    verify_us    <= nxt.vus;
                    tokens_total <= nxt.tok;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor. Each result transaction is matched against the oldest
    // answer still owed; the stall for the next cycle is chosen here too.
    always @(posedge clk or negedge rst_n)
    begin : answer_monitor
        length_answer_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected result: draft_len=%0d in_test=%0d", draft_len, in_test);
                    error_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (draft_len !== want.len)
                    begin
                        $error("draft_len mismatch: expected %0d, actual %0d",
                               want.len, draft_len);
                        error_count++;
                    end
                    if (in_test !== want.test)
                    begin
                        $error("in_test mismatch: expected %0d, actual %0d",
                               want.test, in_test);
                        error_count++;
                    end
                end
            end
            out_stall <= holding_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // One long receiver hold-off, timed in its own process. The sender keeps
    // offering items meanwhile, so the block fills and stalls its input.
    initial
    begin
        wait (pressure_armed);
        @(posedge clk);
        holding_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holding_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_item(input logic [FUNC_W-1:0] op, input logic [VUS_W-1:0] vus,
                              input logic [TOK_W-1:0] tok);
        item_t it;
        it.op  = op;
        it.vus = vus;
        it.tok = tok;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Verify times: the zero floor, one, the top value, full random words and
    // a band of ordinary microsecond counts.
    function automatic logic [VUS_W-1:0] pick_time();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 18)
            return 32'd1;
        if (roll < 26)
            return '1;
        if (roll < 40)
            return $urandom();
        return $urandom_range(5000, 2);
    endfunction

    // Token increments. A flat share yields zero utility, which makes length
    // zero win and drives the hold multiplier up.
    function automatic logic [TOK_W-1:0] pick_delta(input int unsigned flat_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < flat_pct)
            return '0;
        if (roll < flat_pct + 5)
            return TOK_W'($urandom());
        if (roll < flat_pct + 10)
            return 20'hFFFFF - TOK_W'($urandom_range(3));
        return TOK_W'($urandom_range(300, 1));
    endfunction

    // Mostly well-formed verify/round pairs with random content, with a
    // share of lone rounds, lone verifies, unknown codes and restarts.
    task automatic queue_traffic(input int unsigned count, input int unsigned flat_pct);
        int unsigned made;
        int unsigned pick;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                queue_item(FUNC_VERIFY, pick_time(), TOK_W'($urandom()));
                tok_cursor = tok_cursor + pick_delta(flat_pct);
                queue_item(FUNC_ROUND, $urandom(), tok_cursor);
                made += 2;
            end
            else
            begin
                if (pick < 88)
                begin
                    tok_cursor = tok_cursor + pick_delta(flat_pct);
                    queue_item(FUNC_ROUND, $urandom(), tok_cursor);
                end
                else if (pick < 94)
                    queue_item(FUNC_VERIFY, pick_time(), TOK_W'($urandom()));
                else if (pick < 98)
                    queue_item(FUNC_UNKNOWN, $urandom(), TOK_W'($urandom()));
                else
                    queue_item(FUNC_RESTART, $urandom(), TOK_W'($urandom()));
                made += 1;
            end
        end
    endtask

    // Every item answers once, so the block is idle as soon as nothing is
    // queued, offered or owed.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ENABLE:      adapt_on      = data[0];
            CFG_DRAFT_CAP:   cap_reg       = data[LEN_W-1:0];
            CFG_TEST_ROUNDS: rounds_reg    = data[7:0];
            CFG_HOLD_BASE:   hold_base_reg = data;
            default:
            begin
            end
        endcase
    endtask

    task automatic run_phase(input logic en, input logic [7:0] cap, input logic [7:0] rounds,
                             input logic [15:0] hold, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned count,
                             input int unsigned flat_pct, input bit lead_restart,
                             input bit squeeze);
        wait_drained();
        write_reg(CFG_ENABLE, {15'd0, en});
        write_reg(CFG_DRAFT_CAP, {8'd0, cap});
        write_reg(CFG_TEST_ROUNDS, {8'd0, rounds});
        write_reg(CFG_HOLD_BASE, hold);
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        if (lead_restart)
            queue_item(FUNC_RESTART, $urandom(), TOK_W'($urandom()));
        if (squeeze)
            pressure_armed = 1'b1;
        queue_traffic(count, flat_pct);
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Out of reset adaptation is off: an unknown code, a verify that is
        // dropped, a round that only moves the token mark, and a restart that
        // still builds the list from the cap.
        queue_item(FUNC_UNKNOWN, 32'h5A5A_A5A5, 20'h5A5A5);
        queue_item(FUNC_VERIFY, 32'hFFFF_FFFF, 20'h00000);
        queue_item(FUNC_ROUND, 32'h0000_0000, 20'hFFFFF);
        queue_item(FUNC_RESTART, 32'h0000_0000, 20'h00000);
        wait_drained();

        // Widest cap, one round per candidate, shortest hold.
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_DRAFT_CAP, 16'd255);
        write_reg(CFG_TEST_ROUNDS, 16'd1);
        write_reg(CFG_HOLD_BASE, 16'd1);
        queue_item(FUNC_RESTART, 32'h0000_0000, 20'h00000);
        // A round with no verify time pending only sets the mark.
        queue_item(FUNC_ROUND, 32'h0000_0000, 20'h00010);
        // A zero verify time counts as one; the count wraps to its top value.
        queue_item(FUNC_VERIFY, 32'h0000_0000, 20'h00000);
        queue_item(FUNC_ROUND, 32'h0000_0000, 20'h0000F);
        // Largest time against one token gives zero utility.
        queue_item(FUNC_VERIFY, 32'hFFFF_FFFF, 20'h00000);
        queue_item(FUNC_ROUND, 32'h0000_0000, 20'h00010);
        queue_item(FUNC_VERIFY, 32'd1000, 20'h00000);
        queue_item(FUNC_ROUND, 32'h0000_0000, 20'h01398);
        // The fourth candidate closes the test phase and the hold starts.
        queue_item(FUNC_VERIFY, 32'd1, 20'h00000);
        queue_item(FUNC_ROUND, 32'h0000_0000, 20'h01398);
        // Length zero won, so the hold doubles to two rounds; the next measured round only counts it down.
        queue_item(FUNC_VERIFY, 32'd7, 20'h00000);
        queue_item(FUNC_ROUND, 32'hFFFF_FFFF, 20'h013A0);
        queue_item(FUNC_UNKNOWN, 32'hFFFF_FFFF, 20'hFFFFF);
        queue_item(FUNC_RESTART, 32'hFFFF_FFFF, 20'hFFFFF);
        wait_drained();

        // Reset values of cap, rounds and hold base, no idling on either side.
        run_phase(1'b1, 8'd16, 8'd4, 16'd16, 0, 0, 220, 10, 1'b1, 1'b0);
        // Zero cap leaves a single candidate; sender idles half the time.
        run_phase(1'b1, 8'd0, 8'd1, 16'd1, 51, 0, 150, 40, 1'b1, 1'b0);
        // Largest round count and hold base; receiver stalls half the time.
        run_phase(1'b1, 8'd255, 8'd255, 16'hFFFF, 0, 51, 250, 5, 1'b1, 1'b0);
        // Three candidates, mostly flat traffic so the zero winner repeats.
        run_phase(1'b1, 8'd2, 8'd2, 16'd3, 9, 9, 200, 50, 1'b1, 1'b0);
        // Long receiver hold-off against a sender that never idles.
        run_phase(1'b1, 8'd3, 8'd1, 16'd2, 0, 0, 150, 20, 1'b1, 1'b1);
        // Adaptation off: the cap is answered whatever comes in.
        run_phase(1'b0, 8'd128, 8'd8, 16'd100, 51, 51, 60, 0, 1'b1, 1'b0);
        // New settings without a restart, so the old list stays in use.
        run_phase(1'b1, 8'($urandom_range(255, 1)), 8'($urandom_range(8, 1)),
                  16'($urandom_range(20, 1)), 9, 9, 120, 15, 1'b0, 1'b0);

        // Let any stray late result show up before the verdict.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
sv/dlts_pkg.sv
sv/dlts_div.sv
sv/dlts_dp.sv
sv/dlts_ctrl.sv
sv/draft_length_test_and_hold_selector_unit.sv
bench/tb_draft_length_test_and_hold_selector_unit.sv
